// File: src/lerq_pkg.sv
// ----------------------------------------------------------------------------
// lerq_pkg: shared types and constants of the line edit receive queue
// Holds the transaction payload types, the key codes, the controller state
// type and the command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package lerq_pkg;

    localparam int CHAR_W        = 8;
    localparam int FILL_COUNT_W  = 9;
    localparam int DEPTH_DEFAULT = 256;

    localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_RETURN    = 8'h0D;

    // Command codes of an input transaction.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] key_char;
    } in_item_t;

    typedef struct packed {
        logic                    echo_valid;
        logic [CHAR_W-1:0]       echo_char;
        logic                    line_done;
        logic                    dropped;
        logic                    read_valid;
        logic [CHAR_W-1:0]       read_char;
        logic [FILL_COUNT_W-1:0] fill_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

// File: src/lerq_stream_if.sv
// ----------------------------------------------------------------------------
// lerq_stream_if: valid/ready channel
// Carries one payload per transaction; a transaction completes at a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lerq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/lerq_ctrl.sv
// ----------------------------------------------------------------------------
// lerq_ctrl: controller of the line edit receive queue
// Sequences one transaction at a time: capture and memory lookup, update,
// then hold the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lerq_ctrl
    import lerq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     result_ready,
    output logic     item_ready,
    output logic     result_valid,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ST_OUT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/lerq_datapath.sv
// ----------------------------------------------------------------------------
// lerq_datapath: character ring, pointers and result register
// Pointers count modulo twice the depth so that full and empty differ. The
// ring has one write port and one registered read port.
// ----------------------------------------------------------------------------
module lerq_datapath
    import lerq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_cmd_t  cmd,
    input  in_item_t  item_data,
    output out_item_t result_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = $clog2(2 * DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
    localparam logic [PTR_W:0]   PTR_SPAN  = (PTR_W + 1)'(2 * DEPTH);

    logic [CHAR_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  rp_next;
    logic              command_reg;
    logic [CHAR_W-1:0] key_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    out_item_t         result_reg;
    out_item_t         result_next;

    logic [PTR_W-1:0]  wp_dec;
    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;
    logic [PTR_W-1:0]  fill_cur;
    logic [PTR_W-1:0]  fill_new;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_en;

    // Entry index of a pointer: pointer modulo the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] s;
        s = (ptr >= PTR_DEPTH) ? ptr - PTR_DEPTH : ptr;
        return s[IDX_W-1:0];
    endfunction

    // Characters held: write minus read, modulo twice the depth.
    function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] d;
        d = {1'b0, wp} - {1'b0, rp};
        if (wp < rp)
        begin
            d = d + PTR_SPAN;
        end
        return d[PTR_W-1:0];
    endfunction

    // Pointer steps, wrapping at twice the depth.
    assign wp_dec   = (wp_reg == '0) ? PTR_LAST : wp_reg - 1'b1;
    assign wp_inc   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign fill_cur = fill_of(wp_reg, rp_reg);
    assign fill_new = fill_of(wp_next, rp_next);

    // Lookup address: oldest entry for a read, last stored entry for a key.
    assign rd_idx = (item_data.command == CMD_READ) ? slot_of(rp_reg) : slot_of(wp_dec);
    assign wr_idx = slot_of(wp_reg);

    // Update of pointers and result for the captured transaction.
    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        wr_en       = 1'b0;
        result_next = '0;
        if (command_reg == CMD_KEY)
        begin
            if (key_reg == KEY_BACKSPACE)
            begin
                if (fill_cur != '0 && rd_data_reg != KEY_RETURN)
                begin
                    wp_next                = wp_dec;
                    result_next.echo_valid = 1'b1;
                    result_next.echo_char  = KEY_BACKSPACE;
                end
            end
            else if (fill_cur >= PTR_DEPTH)
            begin
                result_next.dropped = 1'b1;
            end
            else
            begin
                wr_en                  = 1'b1;
                wp_next                = wp_inc;
                result_next.echo_valid = 1'b1;
                result_next.echo_char  = key_reg;
                result_next.line_done  = (key_reg == KEY_RETURN);
            end
        end
        else
        begin
            if (fill_cur != '0)
            begin
                rp_next                = rp_inc;
                result_next.read_valid = 1'b1;
                result_next.read_char  = rd_data_reg;
            end
        end
        result_next.fill_count = FILL_COUNT_W'(fill_new);
    end

    // Character ring: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_idx];
        end
        if (cmd.execute && wr_en)
        begin
            mem[wr_idx] <= key_reg;
        end
    end

    // Captured transaction and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= item_data.command;
            key_reg     <= item_data.key_char;
        end
        if (cmd.execute)
        begin
            result_reg <= result_next;
        end
    end

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else if (cmd.execute)
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    assign result_data = result_reg;

endmodule

// File: src/line_edit_receive_queue_unit.sv
// Flow: the result register is written in ST_EXEC and offered in ST_OUT until it is taken.
// One transaction at a time: lookup, update, and result hold;
// the next is accepted at the edge after the result is taken.
// Reset: write and read pointers clear to zero, so the queue is empty; the
// character ring is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// line_edit_receive_queue_unit: terminal receive queue with line editing
// Stores key characters in a ring, handles backspace and carriage return,
// and pops characters on read transactions.
// ----------------------------------------------------------------------------
module line_edit_receive_queue_unit
    import lerq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic          clk,
    input logic          rst_n,
    lerq_stream_if.sink   item,
    lerq_stream_if.source result
);

    ctl_cmd_t  cmd;
    in_item_t  item_data;
    out_item_t result_data;

    assign item_data = item.payload;

    // Controller.
    lerq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .result_ready (result.ready),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .cmd          (cmd)
    );

    // Datapath.
    lerq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_data   (item_data),
        .result_data (result_data)
    );

    assign result.payload = result_data;

endmodule

// File: sim/line_edit_queue_checker.sv
// ----------------------------------------------------------------------------
// line_edit_queue_checker: result checker for the line edit receive queue
// Watches the input and result channels, keeps its own copy of the ring
// and its pointers, predicts the result of every accepted input transaction
// and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module line_edit_queue_checker
    import lerq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_ready,
    input  in_item_t  item_payload,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_item_t result_payload,
    output int        fail_count,
    output int        results_owed
);

    // Pointers count modulo twice the depth so that full and empty differ.
    localparam int PTR_SPAN     = 2 * DEPTH;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;

    logic [CHAR_W-1:0] ring_chars [DEPTH];
    int                write_ptr;
    int                read_ptr;
    out_item_t         expected_results [$];
    int                mismatches;

    assign fail_count = mismatches;

    // Counts a failure and reports only the first few of them.
    function automatic void note_failure(string msg);
        if (mismatches < REPORT_LIMIT)
        begin
            $display("checker: %s", msg);
        end
        mismatches++;
    endfunction

    function automatic void check_field(string field, logic [FILL_COUNT_W-1:0] want,
                                        logic [FILL_COUNT_W-1:0] got);
        if (want !== got)
        begin
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
        end
    endfunction

    // Applies one transaction to the local queue copy and returns its result.
    function automatic out_item_t line_edit_step(in_item_t it);
        out_item_t r;
        int        fill;
        int        prev;
        r    = '0;
        fill = (write_ptr + PTR_SPAN - read_ptr) % PTR_SPAN;
        if (it.command == CMD_KEY)
        begin
            if (it.key_char == KEY_BACKSPACE)
            begin
                // Erase the last character unless the queue is empty or it ends a line.
                if (fill != 0)
                begin
                    prev = (write_ptr + PTR_SPAN - 1) % PTR_SPAN;
                    if (ring_chars[IDX_W'(prev % DEPTH)] != KEY_RETURN)
                    begin
                        write_ptr   = prev;
                        r.echo_valid = 1'b1;
                        r.echo_char  = KEY_BACKSPACE;
                    end
                end
            end
            else if (fill >= DEPTH)
            begin
                r.dropped = 1'b1;
            end
            else
            begin
                ring_chars[IDX_W'(write_ptr % DEPTH)] = it.key_char;
                write_ptr    = (write_ptr + 1) % PTR_SPAN;
                r.echo_valid = 1'b1;
                r.echo_char  = it.key_char;
                r.line_done  = (it.key_char == KEY_RETURN);
            end
        end
        else if (fill != 0)
        begin
            r.read_valid = 1'b1;
            r.read_char  = ring_chars[IDX_W'(read_ptr % DEPTH)];
            read_ptr     = (read_ptr + 1) % PTR_SPAN;
        end
        r.fill_count = FILL_COUNT_W'((write_ptr + PTR_SPAN - read_ptr) % PTR_SPAN);
        return r;
    endfunction

    // Compare results first, then record the prediction for a new transaction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            write_ptr  = 0;
            read_ptr   = 0;
            mismatches = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure("result transaction with no input transaction pending");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("echo_valid", FILL_COUNT_W'(want.echo_valid),
                                FILL_COUNT_W'(result_payload.echo_valid));
                    check_field("echo_char", FILL_COUNT_W'(want.echo_char),
                                FILL_COUNT_W'(result_payload.echo_char));
                    check_field("line_done", FILL_COUNT_W'(want.line_done),
                                FILL_COUNT_W'(result_payload.line_done));
                    check_field("dropped", FILL_COUNT_W'(want.dropped),
                                FILL_COUNT_W'(result_payload.dropped));
                    check_field("read_valid", FILL_COUNT_W'(want.read_valid),
                                FILL_COUNT_W'(result_payload.read_valid));
                    check_field("read_char", FILL_COUNT_W'(want.read_char),
                                FILL_COUNT_W'(result_payload.read_char));
                    check_field("fill_count", want.fill_count, result_payload.fill_count);
                end
            end
            if (item_valid && item_ready)
            begin
                expected_results.push_back(line_edit_step(item_payload));
            end
        end
        results_owed <= expected_results.size();
    end

endmodule

// File: sim/line_edit_receive_queue_unit_test.sv
// ----------------------------------------------------------------------------
// line_edit_receive_queue_unit_test: testbench of the line edit receive queue
// Drives key and read transactions: a short directed sequence for the edge
// cases, then typed lines with random content, noise, and one pass that fills
// the queue past full and drains it. Both channels stall at random.
// ----------------------------------------------------------------------------
module line_edit_receive_queue_unit_test
    import lerq_pkg::*;
();

    localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 12;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   sent_count;
    int   fail_count;
    int   results_owed;

    lerq_stream_if #(.payload_t(in_item_t))  item_ch ();
    lerq_stream_if #(.payload_t(out_item_t)) result_ch ();

    line_edit_receive_queue_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    line_edit_queue_checker #(
        .DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_ch.valid),
        .item_ready     (item_ch.ready),
        .item_payload   (item_ch.payload),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .result_payload (result_ch.payload),
        .fail_count     (fail_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sends one transaction, with a random gap before it, and returns at the
    // edge where it is accepted.
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= in_item_t'{command: cmd, key_char: key};
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // A random byte that is neither a backspace nor a carriage return.
    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] ch;
        do
        begin
            ch = CHAR_W'($urandom_range(255));
        end
        while (ch == KEY_BACKSPACE || ch == KEY_RETURN);
        return ch;
    endfunction

    // Types a line with some backspaces, usually ends it, then reads a while.
    task automatic type_line();
        int                n;
        int                pops;
        logic [CHAR_W-1:0] ch;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
            begin
                ch = KEY_BACKSPACE;
            end
            else
            begin
                ch = CHAR_W'($urandom_range(255));
            end
            send_item(CMD_KEY, ch);
        end
        if ($urandom_range(99) < 80)
        begin
            send_item(CMD_KEY, KEY_RETURN);
            if ($urandom_range(99) < 25)
            begin
                send_item(CMD_KEY, KEY_BACKSPACE);
            end
        end
        pops = $urandom_range(0, n + 6);
        repeat (pops)
        begin
            send_item(CMD_READ, CHAR_W'($urandom_range(255)));
        end
    endtask

    task automatic random_noise(input int n);
        repeat (n)
        begin
            send_item(1'($urandom_range(1)), CHAR_W'($urandom_range(255)));
        end
    endtask

    // Overfills the queue, edits at full, then drains it past empty.
    task automatic fill_and_drain();
        repeat (QUEUE_DEPTH + 4)
        begin
            send_item(CMD_KEY, plain_char());
        end
        send_item(CMD_KEY, KEY_RETURN);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_RETURN);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, plain_char());
        send_item(CMD_KEY, KEY_RETURN);
        repeat (QUEUE_DEPTH + 2)
        begin
            send_item(CMD_READ, CHAR_W'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int tx_idle, input int rx_idle, input bit with_fill);
        int start;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        if (with_fill)
        begin
            fill_and_drain();
        end
        start = sent_count;
        while (sent_count - start < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                type_line();
            end
            else
            begin
                random_noise($urandom_range(1, 8));
            end
        end
    endtask

    // Result side: ready follows the current stall rate every cycle.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int waited;
        waited          = 0;
        sent_count      = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 59;

        // Empty queue: read and backspace do nothing.
        send_item(CMD_READ, 8'hFF);
        send_item(CMD_KEY, KEY_BACKSPACE);
        // Extreme bytes, an erase, and a line end that cannot be erased.
        send_item(CMD_KEY, 8'h00);
        send_item(CMD_KEY, 8'hFF);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_RETURN);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, 8'h41);
        // Reads carry a key byte that must be ignored.
        send_item(CMD_READ, 8'hAA);
        send_item(CMD_READ, 8'h55);
        send_item(CMD_READ, 8'h00);
        send_item(CMD_READ, 8'hFF);
        send_item(CMD_KEY, 8'h7F);
        send_item(CMD_KEY, 8'h80);
        send_item(CMD_KEY, 8'h55);
        send_item(CMD_KEY, 8'hAA);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_KEY, KEY_BACKSPACE);
        send_item(CMD_READ, 8'h0F);

        run_phase(6, 59, 1'b0);
        run_phase(59, 6, 1'b1);
        run_phase(0, 0, 1'b0);
        item_ch.valid <= 1'b0;

        // Wait for every predicted result, then let the design drain before the verdict.
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (results_owed != 0 && waited < STALL_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
